// ===== design/vector3_normalize_defines.svh =====
// assertion macros used by the vector normalizer top level
// no dependencies
`ifndef VECTOR3_NORMALIZE_DEFINES_SVH
`define VECTOR3_NORMALIZE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define V3N_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define V3N_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define V3N_ASSERT(label, clk, rst, prop)
`define V3N_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== design/v3n_pkg.sv =====
// constants for the vector normalizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package v3n_pkg;
   localparam int NUM_LANES = 3;
   localparam int OUT_WIDTH = 16;
endpackage
`default_nettype wire

// ===== design/v3n_sqrt_stage.sv =====
// one restoring square root step: one result bit per stage, registered
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
module v3n_sqrt_stage #(
   parameter int RAD_WIDTH  = 34,
   parameter int ROOT_WIDTH = 17,
   parameter int BIT_POS    = 0
) (
   input  wire logic                  clock,
   input  wire logic [RAD_WIDTH-1:0]  rem_in,
   input  wire logic [ROOT_WIDTH-1:0] root_in,
   output logic      [RAD_WIDTH-1:0]  rem_out,
   output logic      [ROOT_WIDTH-1:0] root_out
);
   logic [RAD_WIDTH+1:0] trial;
   logic [RAD_WIDTH+1:0] rem_x;
   logic [RAD_WIDTH-1:0] rem_in_n;
   logic [ROOT_WIDTH-1:0] root_in_n;
   always_comb begin
      rem_x = {2'b00, rem_in};
      trial = (({{(RAD_WIDTH+2-ROOT_WIDTH){1'b0}}, root_in}) << (BIT_POS + 1))
              | ((RAD_WIDTH+2)'(1) << (2 * BIT_POS));
      if (rem_x >= trial) begin
         rem_in_n  = RAD_WIDTH'(rem_x - trial);
         root_in_n = root_in | (ROOT_WIDTH'(1) << BIT_POS);
      end else begin
         rem_in_n  = rem_in;
         root_in_n = root_in;
      end
   end
   always_ff @(posedge clock) begin
      rem_out  <= rem_in_n;
      root_out <= root_in_n;
   end
endmodule
`default_nettype wire

// ===== design/v3n_div_stage.sv =====
// one restoring division step for a lane: one quotient bit per stage
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
module v3n_div_stage #(
   parameter int NUM_WIDTH = 30,
   parameter int DEN_WIDTH = 17,
   parameter int BIT_POS   = 0
) (
   input  wire logic                 clock,
   input  wire logic [NUM_WIDTH-1:0] rem_in,
   input  wire logic [DEN_WIDTH-1:0] den,
   input  wire logic [NUM_WIDTH-1:0] quo_in,
   output logic      [NUM_WIDTH-1:0] rem_out,
   output logic      [NUM_WIDTH-1:0] quo_out
);
   localparam int W = NUM_WIDTH + DEN_WIDTH;
   logic [W-1:0] shifted;
   logic [NUM_WIDTH-1:0] rem_n;
   logic [NUM_WIDTH-1:0] quo_n;
   always_comb begin
      shifted = W'(den) << BIT_POS;
      if ({{DEN_WIDTH{1'b0}}, rem_in} >= shifted) begin
         rem_n = NUM_WIDTH'({{DEN_WIDTH{1'b0}}, rem_in} - shifted);
         quo_n = quo_in | (NUM_WIDTH'(1) << BIT_POS);
      end else begin
         rem_n = rem_in;
         quo_n = quo_in;
      end
   end
   always_ff @(posedge clock) begin
      rem_out <= rem_n;
      quo_out <= quo_n;
   end
endmodule
`default_nettype wire

// ===== design/v3n_lane.sv =====
// one component lane: pipelined divider of magnitude by length
// depends on v3n_div_stage
`timescale 1ns / 1ps
`default_nettype none
module v3n_lane #(
   parameter int MAG_WIDTH  = 16,
   parameter int FRAC_BITS  = 14,
   parameter int LEN_WIDTH  = 17
) (
   input  wire logic                           clock,
   input  wire logic [MAG_WIDTH-1:0]           mag,
   input  wire logic [LEN_WIDTH-1:0]           len,
   output logic      [MAG_WIDTH+FRAC_BITS-1:0] quo
);
   localparam int NW = MAG_WIDTH + FRAC_BITS;
   logic [NW-1:0] rem_s [NW+1];
   logic [NW-1:0] quo_s [NW+1];
   logic [LEN_WIDTH-1:0] den_s [NW];
   assign rem_s[0] = {mag, {FRAC_BITS{1'b0}}};
   assign quo_s[0] = '0;
   assign den_s[0] = len;
   for (genvar k = 0; k < NW; k++) begin : g_step
      v3n_div_stage #(
         .NUM_WIDTH(NW), .DEN_WIDTH(LEN_WIDTH), .BIT_POS(NW - 1 - k)
      ) u_stage (
         .clock  (clock),
         .rem_in (rem_s[k]),
         .den    (den_s[k]),
         .quo_in (quo_s[k]),
         .rem_out(rem_s[k+1]),
         .quo_out(quo_s[k+1])
      );
      if (k < NW - 1) begin : g_den
         always_ff @(posedge clock) begin
            den_s[k+1] <= den_s[k];
         end
      end
   end
   assign quo = quo_s[NW];
endmodule
`default_nettype wire

// ===== design/vector3_normalize.sv =====
// top level of the vector normalizer: sqrt pipeline, three division lanes, merge
// depends on v3n_pkg, v3n_sqrt_stage, v3n_lane and the defines header
//
// usage:
//   drive req_comp_x/y/z and pulse start; busy is always low, so a word is
//   taken every cycle. each word yields one result word on the rsp_ ports,
//   marked by rsp_valid for exactly one cycle, in input order.
// pipeline: square root stages, one root bit per stage for the COMP_WIDTH + 1
//   bit root, then division stages, one quotient bit per stage in each of three
//   parallel lanes for the COMP_WIDTH + UNIT_FRAC_BITS bit quotient, then one
//   merge register.
// throughput: one word per cycle, set by the fully pipelined stages.
// reset: clears the valid pipeline only; the data registers are not reset.
// the receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps
`default_nettype none
`include "vector3_normalize_defines.svh"
module vector3_normalize #(
   parameter int COMP_WIDTH     = 16,
   parameter int UNIT_FRAC_BITS = 14
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic signed [COMP_WIDTH-1:0]         req_comp_x,
   input  wire logic signed [COMP_WIDTH-1:0]         req_comp_y,
   input  wire logic signed [COMP_WIDTH-1:0]         req_comp_z,
   output logic                                      rsp_valid,
   output logic signed [v3n_pkg::OUT_WIDTH-1:0]      rsp_unit_x,
   output logic signed [v3n_pkg::OUT_WIDTH-1:0]      rsp_unit_y,
   output logic signed [v3n_pkg::OUT_WIDTH-1:0]      rsp_unit_z,
   output logic        [v3n_pkg::OUT_WIDTH-1:0]      rsp_length,
   output logic                                      rsp_zero_vector
);
   localparam int NL   = v3n_pkg::NUM_LANES;
   localparam int OW   = v3n_pkg::OUT_WIDTH;
   localparam int RW   = 2 * COMP_WIDTH + 2;
   localparam int LW   = COMP_WIDTH + 1;
   localparam int SQ_D = LW;
   localparam int QW   = COMP_WIDTH + UNIT_FRAC_BITS;
   localparam int DV_D = QW;
   localparam int TOT  = SQ_D + DV_D;

   logic [COMP_WIDTH-1:0] mag_in [NL];
   logic                  neg_in [NL];
   logic [RW-1:0]         sumsq;
   logic [RW-1:0]         sq_rem  [SQ_D+1];
   logic [LW-1:0]         sq_root [SQ_D+1];
   logic [COMP_WIDTH-1:0] mag_d   [SQ_D+1][NL];
   logic [NL-1:0]         neg_ff  [TOT+1];
   logic [LW-1:0]         len_ff  [DV_D+1];
   logic [QW-1:0]         quo     [NL];
   logic [TOT:0]          valid_ff;
   logic [TOT:0]          valid_in;
   logic [OW-1:0]         unit_in [NL];
   logic                  zero_in;

   assign busy = 1'b0;

   always_comb begin
      sumsq = '0;
      for (int i = 0; i < NL; i++) begin
         logic signed [COMP_WIDTH-1:0] c;
         c = (i == 0) ? req_comp_x : ((i == 1) ? req_comp_y : req_comp_z);
         neg_in[i] = c[COMP_WIDTH-1];
         mag_in[i] = c[COMP_WIDTH-1] ? COMP_WIDTH'(-c) : COMP_WIDTH'(c);
      end
      sumsq = RW'(mag_in[0]) * RW'(mag_in[0]) + RW'(mag_in[1]) * RW'(mag_in[1])
            + RW'(mag_in[2]) * RW'(mag_in[2]);
   end

   assign sq_rem[0]  = sumsq;
   assign sq_root[0] = '0;
   assign neg_ff[0]  = {neg_in[2], neg_in[1], neg_in[0]};
   for (genvar l = 0; l < NL; l++) begin : g_mag0
      assign mag_d[0][l] = mag_in[l];
   end

   for (genvar k = 0; k < SQ_D; k++) begin : g_sqrt
      v3n_sqrt_stage #(
         .RAD_WIDTH(RW), .ROOT_WIDTH(LW), .BIT_POS(SQ_D - 1 - k)
      ) u_sqrt (
         .clock   (clock),
         .rem_in  (sq_rem[k]),
         .root_in (sq_root[k]),
         .rem_out (sq_rem[k+1]),
         .root_out(sq_root[k+1])
      );
      always_ff @(posedge clock) begin
         for (int l = 0; l < NL; l++) begin
            mag_d[k+1][l] <= mag_d[k][l];
         end
      end
   end

   for (genvar k = 0; k < TOT; k++) begin : g_neg
      always_ff @(posedge clock) begin
         neg_ff[k+1] <= neg_ff[k];
      end
   end

   assign len_ff[0] = sq_root[SQ_D];
   for (genvar k = 0; k < DV_D; k++) begin : g_len
      always_ff @(posedge clock) begin
         len_ff[k+1] <= len_ff[k];
      end
   end

   for (genvar l = 0; l < NL; l++) begin : g_lane
      v3n_lane #(
         .MAG_WIDTH(COMP_WIDTH), .FRAC_BITS(UNIT_FRAC_BITS), .LEN_WIDTH(LW)
      ) u_lane (
         .clock(clock),
         .mag  (mag_d[SQ_D][l]),
         .len  (sq_root[SQ_D]),
         .quo  (quo[l])
      );
   end

   // merge: sign, zero vector
   always_comb begin
      zero_in = (len_ff[DV_D] == '0);
      for (int l = 0; l < NL; l++) begin
         logic [OW-1:0] q16;
         q16 = OW'(quo[l]);
         if (zero_in) begin
            unit_in[l] = '0;
         end else if (neg_ff[TOT][l]) begin
            unit_in[l] = OW'(-q16);
         end else begin
            unit_in[l] = q16;
         end
      end
   end

   always_comb begin
      valid_in = {valid_ff[TOT-1:0], start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_unit_x      <= unit_in[0];
      rsp_unit_y      <= unit_in[1];
      rsp_unit_z      <= unit_in[2];
      rsp_length      <= OW'(len_ff[DV_D]);
      rsp_zero_vector <= zero_in;
   end

   assign rsp_valid = valid_ff[TOT];

   `V3N_ASSERT(a_busy_low, clock, reset, busy == 1'b0)
   `V3N_ASSERT(a_valid_lat, clock, reset, start |-> ##(TOT+1) rsp_valid)
   `V3N_ASSERT(a_zero_units, clock, reset,
      (rsp_valid && rsp_zero_vector) |-> (rsp_unit_x == '0 && rsp_length == '0))
   `V3N_ASSERT_NR(a_reset_clear, clock, reset |=> !rsp_valid)
endmodule
`default_nettype wire
